[design/septu_pkg.sv]
// ----------------------------------------------------------------------------
// Septet unpacker package
// Shared widths and the result and queue entry types of the septet unpacker.
// ----------------------------------------------------------------------------
package septu_pkg;

    localparam int unsigned SEPTET_W = 7;
    localparam int unsigned OCTET_W  = 8;
    localparam int unsigned CHAR_W   = 8;

    typedef struct packed {
        logic [SEPTET_W-1:0] septet;
        logic [CHAR_W-1:0]   char_index;
        logic                last_char;
        logic                short_input;
    } result_t;

    // One accepted octet gives at most two results; both travel in one entry.
    typedef struct packed {
        logic    two;
        result_t first;
        result_t second;
    } entry_t;

endpackage

[design/septu_front.sv]
// ----------------------------------------------------------------------------
// Septet unpacker front end
// Accepts octets, tracks the bit accumulator and message position, and turns
// each octet into a queue entry holding the characters it releases.
// ----------------------------------------------------------------------------
module septu_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            data_byte,
    input  logic                  msg_start,
    input  logic                  msg_end,
    input  logic                  header_present,
    input  logic [7:0]            septet_total,
    input  logic                  queue_full,
    output logic                  push,
    output septu_pkg::entry_t     push_entry
);
    import septu_pkg::*;

    localparam logic [11:0] RECIP_7    = 12'd2341;  // ceil(2^14 / 7)
    localparam logic [11:0] ROUND_UP   = 12'd14;    // one octet of length plus 6
    localparam logic [4:0]  SEPTET_LEN = 5'd7;
    localparam logic [4:0]  TWO_LEN    = 5'd14;

    logic [13:0] acc_reg, acc_next;
    logic [3:0]  held_reg, held_next;
    logic [8:0]  pos_reg, pos_next;
    logic [8:0]  skip_reg, skip_next;
    logic [7:0]  tot_reg, tot_next;
    logic [7:0]  chars_reg, chars_next;

    logic [13:0] acc0, acc1;
    logic [3:0]  held0;
    logic [4:0]  held1, held_left;
    logic [8:0]  pos0, pos1, pos2, tot_ext;
    logic [8:0]  skip0;
    logic [7:0]  tot0, chars0, chars1, chars2;
    logic        active, take_a, take_b, emit_a, emit_b, err_only;
    logic [11:0] skip_arg;
    logic [23:0] skip_prod;
    result_t     res_a, res_b;
    entry_t      entry;
    logic        accept;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    // Septets to skip for a header of the given length: ceil((L+1)*8/7),
    // taken as a multiplication by the reciprocal of seven.
    assign skip_arg  = {1'b0, data_byte, 3'b000} + ROUND_UP;
    assign skip_prod = skip_arg * RECIP_7;

    always_comb
    begin
        acc0   = acc_reg;
        held0  = held_reg;
        pos0   = pos_reg;
        chars0 = chars_reg;
        tot0   = tot_reg;
        skip0  = skip_reg;
        if (msg_start)
        begin
            acc0   = '0;
            held0  = '0;
            pos0   = '0;
            chars0 = '0;
            tot0   = septet_total;
            skip0  = header_present ? skip_prod[22:14] : 9'd0;
        end

        tot_ext = {1'b0, tot0};
        active  = pos0 < tot_ext;
        acc1    = acc0 | (14'(data_byte) << held0);
        held1   = {1'b0, held0} + 5'(OCTET_W);

        // The first septet is always complete once an octet has been added.
        take_a = active;
        pos1   = pos0 + {8'd0, take_a};
        take_b = take_a && (held1 >= TWO_LEN) && (pos1 < tot_ext);
        pos2   = pos1 + {8'd0, take_b};
        emit_a = take_a && (pos0 >= skip0);
        emit_b = take_b && (pos1 >= skip0);
        chars1 = chars0 + {7'd0, emit_a};
        chars2 = chars1 + {7'd0, emit_b};

        res_a.septet      = acc1[6:0];
        res_a.char_index  = chars0;
        res_a.last_char   = (pos1 == tot_ext);
        res_a.short_input = 1'b0;
        res_b.septet      = acc1[13:7];
        res_b.char_index  = chars1;
        res_b.last_char   = (pos2 == tot_ext);
        res_b.short_input = 1'b0;

        entry.two    = emit_a && emit_b;
        entry.first  = emit_a ? res_a : res_b;
        entry.second = res_b;
        err_only     = 1'b0;

        held_left = held1 - (take_b ? TWO_LEN : SEPTET_LEN);
        if (!active)
        begin
            acc_next  = acc0;
            held_next = held0;
        end
        else
        begin
            acc_next  = take_b ? 14'd0 : (acc1 >> SEPTET_W);
            held_next = held_left[3:0];
        end
        pos_next   = pos2;
        chars_next = chars2;
        tot_next   = tot0;
        skip_next  = skip0;

        if (msg_end)
        begin
            if ((pos2 < tot_ext) && (tot_ext > skip0))
            begin
                if (entry.two)
                begin
                    entry.second.short_input = 1'b1;
                end
                else if (emit_a || emit_b)
                begin
                    entry.first.short_input = 1'b1;
                end
                else
                begin
                    entry.first.septet      = '0;
                    entry.first.char_index  = chars2;
                    entry.first.last_char   = 1'b0;
                    entry.first.short_input = 1'b1;
                    err_only                = 1'b1;
                end
            end
            pos_next = tot_ext;
        end
    end

    assign push       = accept && (emit_a || emit_b || err_only);
    assign push_entry = entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            held_reg  <= '0;
            pos_reg   <= '0;
            skip_reg  <= '0;
            tot_reg   <= '0;
            chars_reg <= '0;
        end
        else if (accept)
        begin
            acc_reg   <= acc_next;
            held_reg  <= held_next;
            pos_reg   <= pos_next;
            skip_reg  <= skip_next;
            tot_reg   <= tot_next;
            chars_reg <= chars_next;
        end
    end

    // The position never runs past the total septet count.
    assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= {1'b0, tot_reg})
        else $error("septet position beyond total");

    // While a message is still open, fewer than a whole septet of bits wait.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg < {1'b0, tot_reg}) |-> (held_reg < 4'd7))
        else $error("whole septet left in accumulator");

endmodule

[design/septu_queue.sv]
// ----------------------------------------------------------------------------
// Septet unpacker queue
// Short first-in first-out store of entries between front and back ends.
// ----------------------------------------------------------------------------
module septu_queue
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  septu_pkg::entry_t push_entry,
    input  logic              pop,
    output logic              full,
    output logic              empty,
    output septu_pkg::entry_t head
);
    import septu_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    entry_t             store_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full  = (count_reg == DEPTH_CNT);
    assign empty = (count_reg == '0);
    assign head  = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        priority if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("queue count beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> (rd_ptr_reg == wr_ptr_reg))
        else $error("queue pointers apart while empty");

endmodule

[design/septu_back.sv]
// ----------------------------------------------------------------------------
// Septet unpacker back end
// Drains queue entries onto the output stream, one or two beats per entry.
// ----------------------------------------------------------------------------
module septu_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               empty,
    input  septu_pkg::entry_t  head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output septu_pkg::result_t out_result
);
    import septu_pkg::*;

    logic sub_reg, sub_next;
    logic beat;

    assign out_valid  = !empty;
    assign out_result = sub_reg ? head.second : head.first;
    assign beat       = out_valid && out_ready;
    assign pop        = beat && (!head.two || sub_reg);

    always_comb
    begin
        sub_next = sub_reg;
        if (beat)
        begin
            sub_next = head.two && !sub_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg <= 1'b0;
        end
        else
        begin
            sub_reg <= sub_next;
        end
    end

    // The second half is only ever pending on a two-character entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        sub_reg |-> (!empty && head.two))
        else $error("second character pending without a two-character entry");

endmodule

[design/septet_unpacker_core.sv]
// ----------------------------------------------------------------------------
// Septet unpacker core
// Unpacks 7-bit characters from the packed octets of a short message.
// ----------------------------------------------------------------------------
// A character is registered in the queue before it appears on the output.
// Throughput: one octet per cycle while the queue is not full; an octet giving two
// characters takes two output beats, and the queue of QUEUE_DEPTH entries absorbs the difference.
// Reset (rst_n low, asynchronous): queue emptied, message state cleared.
// ----------------------------------------------------------------------------
module septet_unpacker_core
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] data_byte, [15:8] septet_total
    input  logic [1:0]  s_tuser,   // [0] msg_start, [1] header_present
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [6:0] septet, [14:7] char_index, [15] zero
    output logic        m_tuser,   // [0] short_input
    output logic        m_tlast
);
    import septu_pkg::*;

    logic    push, pop, full, empty;
    entry_t  push_entry, head;
    result_t out_result;

    septu_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .data_byte      (s_tdata[7:0]),
        .msg_start      (s_tuser[0]),
        .msg_end        (s_tlast),
        .header_present (s_tuser[1]),
        .septet_total   (s_tdata[15:8]),
        .queue_full     (full),
        .push           (push),
        .push_entry     (push_entry)
    );

    septu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (full),
        .empty      (empty),
        .head       (head)
    );

    septu_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .empty      (empty),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (out_result)
    );

    assign m_tdata = {1'b0, out_result.char_index, out_result.septet};
    assign m_tuser = out_result.short_input;
    assign m_tlast = out_result.last_char;

endmodule
